### rtl/tristate_remote_frame_sender_macros.svh
// assertion macros for the tristate remote frame sender
// expects clk and arst_n in the including scope
`ifndef TRISTATE_REMOTE_FRAME_SENDER_MACROS_SVH
`define TRISTATE_REMOTE_FRAME_SENDER_MACROS_SVH

// same-cycle implication
`define TRFS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TRFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/trfs_pkg.sv
// shared types, constants and the frame byte function of the frame sender
// no dependencies
package trfs_pkg;

	localparam int FRAME_BYTES_DEF = 16;
	localparam int IDX_W = 5;

	localparam logic [7:0] CODE_FLOAT = 8'h8e;
	localparam logic [7:0] CODE_ZERO  = 8'h88;
	localparam logic [7:0] CODE_ONE   = 8'hee;
	localparam logic [7:0] CODE_SYNC  = 8'h80;

	localparam logic [7:0] REPEAT_RESET = 8'd12;
	localparam logic [2:0] MAX_UNIT = 3'd4;

	localparam logic [IDX_W-1:0] UNIT_POS  = 5'd5;
	localparam logic [IDX_W-1:0] FUNC_POS  = 5'd10;
	localparam logic [IDX_W-1:0] FUNC2_POS = 5'd11;
	localparam logic [IDX_W-1:0] SYNC_POS  = 5'd12;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	localparam logic REG_REPEAT = 1'b0;

	typedef struct packed {
		logic line_level;
		logic sending;
		logic command_accepted;
	} result_t;

	typedef struct packed {
		logic out_valid;
		logic skid_valid;
	} skid_stat_t;

	function automatic logic [7:0] frame_byte(input logic [IDX_W-1:0] idx,
			input logic [4:0] group, input logic [2:0] unit, input logic on);
		logic [7:0] b;
		b = 8'h00;
		if (idx < UNIT_POS) begin
			b = group[idx[2:0]] ? CODE_ZERO : CODE_FLOAT;
		end else if (idx < FUNC_POS) begin
			b = ((idx - UNIT_POS) == {2'b00, unit}) ? CODE_ZERO : CODE_FLOAT;
		end else if (idx == FUNC_POS) begin
			b = on ? CODE_ZERO : CODE_ONE;
		end else if (idx == FUNC2_POS) begin
			b = on ? CODE_ONE : CODE_ZERO;
		end else if (idx == SYNC_POS) begin
			b = CODE_SYNC;
		end
		return b;
	endfunction

endpackage

### rtl/tristate_remote_frame_sender.sv
// tristate remote frame sender, top level
// depends on trfs_pkg, trfs_frame_mem, trfs_out_skid and the assertion macros
//
// input channel (in_valid/in_stall): each request is a tick (kind 0) or a
// command (kind 1) with group_bits, unit_index and function_on. a command
// with unit_index 0..4 builds a new frame and restarts sending for
// repeat_count repeats; other unit values are rejected and change nothing.
// each tick while repeats remain drives the next frame bit, msb first.
// output channel (out_valid/out_stall): exactly one result per request,
// carrying line_level, sending and command_accepted.
// a result is registered in the output register, or in the skid entry
// while the output register is held. throughput: one request per cycle
// while in_stall is low; the frame byte is read, registered, from the frame
// memory before the tick that needs it. after a command the frame memory is
// refilled in the background, one byte a cycle, always ahead of the byte sent.
// stall: the output register and one skid entry hold results; in_stall rises
// only while both are full.
// reset: positions and repeats clear, the line goes low, repeat_count is 12.
// config: apb register 0 at address 0 holds repeat_count; pready is always high.
`include "tristate_remote_frame_sender_macros.svh"

module tristate_remote_frame_sender #(
	parameter int FRAME_BYTES = trfs_pkg::FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [4:0]  group_bits,
	input  logic [2:0]  unit_index,
	input  logic        function_on,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        line_level,
	output logic        sending,
	output logic        command_accepted,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(FRAME_BYTES);
	localparam logic [AW-1:0] LAST = AW'(FRAME_BYTES - 1);

	logic [7:0]    repeat_count_q;
	logic [2:0]    bit_pos_q, bit_pos_d;
	logic [AW-1:0] byte_pos_q, byte_pos_d;
	logic [7:0]    repeats_q, repeats_d;
	logic          line_q, line_d;

	logic          sweep_active_q;
	logic [AW-1:0] sweep_addr_q;
	logic [4:0]    desc_group_q;
	logic [2:0]    desc_unit_q;
	logic          desc_on_q;

	logic          in_acc;
	logic          cmd_ok;
	logic          start;
	logic          do_tick;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [7:0]    rd_byte;

	trfs_pkg::result_t    res;
	trfs_pkg::result_t    out_res;
	trfs_pkg::skid_stat_t skid_stat;

	// apb register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_count_q <= trfs_pkg::REPEAT_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == trfs_pkg::REG_REPEAT)) begin
			repeat_count_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == trfs_pkg::REG_REPEAT) begin
			prdata = {24'h000000, repeat_count_q};
		end
	end

	// request decode
	assign in_acc  = in_valid && !in_stall;
	assign cmd_ok  = (kind == trfs_pkg::KIND_CMD) && (unit_index <= trfs_pkg::MAX_UNIT);
	assign start   = in_acc && cmd_ok;
	assign do_tick = in_acc && (kind == trfs_pkg::KIND_TICK) && (repeats_q != 8'd0);

	// position and repeat update
	always_comb begin
		bit_pos_d  = bit_pos_q;
		byte_pos_d = byte_pos_q;
		repeats_d  = repeats_q;
		line_d     = line_q;
		if (start) begin
			bit_pos_d  = '0;
			byte_pos_d = '0;
			repeats_d  = repeat_count_q;
		end else if (do_tick) begin
			line_d    = rd_byte[3'd7 - bit_pos_q];
			bit_pos_d = bit_pos_q + 3'd1;
			if (bit_pos_q == 3'd7) begin
				if (byte_pos_q == LAST) begin
					byte_pos_d = '0;
					repeats_d  = repeats_q - 8'd1;
				end else begin
					byte_pos_d = byte_pos_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q  <= '0;
			byte_pos_q <= '0;
			repeats_q  <= '0;
			line_q     <= 1'b0;
		end else begin
			bit_pos_q  <= bit_pos_d;
			byte_pos_q <= byte_pos_d;
			repeats_q  <= repeats_d;
			line_q     <= line_d;
		end
	end

	// frame fill: byte 0 with the command, the rest one per cycle after it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_active_q <= 1'b0;
			sweep_addr_q   <= '0;
		end else if (start) begin
			sweep_active_q <= 1'b1;
			sweep_addr_q   <= AW'(1);
		end else if (sweep_active_q) begin
			if (sweep_addr_q == LAST) begin
				sweep_active_q <= 1'b0;
			end else begin
				sweep_addr_q <= sweep_addr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			desc_group_q <= group_bits;
			desc_unit_q  <= unit_index;
			desc_on_q    <= function_on;
		end
	end

	assign mem_we    = start || sweep_active_q;
	assign mem_waddr = start ? '0 : sweep_addr_q;
	assign mem_wdata = start
		? trfs_pkg::frame_byte('0, group_bits, unit_index, function_on)
		: trfs_pkg::frame_byte(trfs_pkg::IDX_W'(sweep_addr_q), desc_group_q,
			desc_unit_q, desc_on_q);

	trfs_frame_mem #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_frame_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (byte_pos_d),
		.rdata (rd_byte)
	);

	// results
	assign res.line_level       = line_d;
	assign res.sending          = (repeats_d != 8'd0);
	assign res.command_accepted = start;

	trfs_out_skid u_out_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_acc),
		.push_data (res),
		.out_stall (out_stall),
		.out_data  (out_res),
		.stat      (skid_stat)
	);

	assign in_stall         = skid_stat.skid_valid;
	assign out_valid        = skid_stat.out_valid;
	assign line_level       = out_res.line_level;
	assign sending          = out_res.sending;
	assign command_accepted = out_res.command_accepted;

	`TRFS_ASSERT_IMPL(a_skid_behind_out, skid_stat.skid_valid, skid_stat.out_valid,
		"skid entry held without an output entry")
	`TRFS_ASSERT_IMPL(a_fill_ahead, sweep_active_q, byte_pos_q < sweep_addr_q,
		"frame byte sent before it was filled")
	`TRFS_ASSERT_NEXT(a_cmd_restart, start,
		(bit_pos_q == 3'd0) && (byte_pos_q == '0) && (repeats_q == $past(repeat_count_q)),
		"accepted command did not restart the frame")

endmodule

### rtl/trfs_frame_mem.sv
// frame byte store: one write port, one registered read port
// write-to-read forwarding when both hit the same entry; uses no package
module trfs_frame_mem #(
	parameter int FRAME_BYTES = 16
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(FRAME_BYTES)-1:0] waddr,
	input  logic [7:0]                     wdata,
	input  logic [$clog2(FRAME_BYTES)-1:0] raddr,
	output logic [7:0]                     rdata
);

	logic [7:0] mem [FRAME_BYTES];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/trfs_out_skid.sv
// result output register with one skid entry
// depends on trfs_pkg for the result and status types
module trfs_out_skid (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  trfs_pkg::result_t    push_data,
	input  logic                 out_stall,
	output trfs_pkg::result_t    out_data,
	output trfs_pkg::skid_stat_t stat
);

	trfs_pkg::result_t out_q;
	trfs_pkg::result_t skid_q;
	logic              out_valid_q;
	logic              skid_valid_q;
	logic              pop;

	assign pop = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else if (!push) begin
					out_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (!out_valid_q) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	assign out_data = out_q;
	assign stat.out_valid = out_valid_q;
	assign stat.skid_valid = skid_valid_q;

endmodule

### tb/tb_tristate_remote_frame_sender.sv
// testbench for the tristate remote frame sender: directed rows, then random
// command/tick sequences checked against a built-in frame and line predictor
// depends on trfs_pkg and the tristate_remote_frame_sender top level
`timescale 1ns / 100ps

module tb_tristate_remote_frame_sender;

	localparam int FB = trfs_pkg::FRAME_BYTES_DEF;
	localparam int HOLD_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS = 40;
	localparam int N_PHASES = 8;
	localparam int HOLD_PHASE = 1;
	localparam int QUIET_PHASE = 5;
	localparam int RND_PHASE = 6;
	localparam int N_DIR = 25;
	localparam logic [2:0] ADDR_REPEAT = 3'({trfs_pkg::REG_REPEAT, 2'b00});

	typedef enum logic {ROW_REQ, ROW_CFG} row_op_t;
	typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	typedef struct {
		row_op_t           op;
		logic              k;
		logic [4:0]        grp;
		logic [2:0]        unit;
		logic              fon;
		logic [7:0]        rpt;
		bit                typed;
		trfs_pkg::result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [4:0]  group_bits;
	logic [2:0]  unit_index;
	logic        function_on;
	logic        out_valid;
	logic        out_stall;
	logic        line_level;
	logic        sending;
	logic        command_accepted;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tristate_remote_frame_sender u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind),
		.group_bits(group_bits), .unit_index(unit_index), .function_on(function_on),
		.out_valid(out_valid), .out_stall(out_stall), .line_level(line_level),
		.sending(sending), .command_accepted(command_accepted),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [7:0] tx_frame [FB];
	logic [2:0] tx_bit;
	int         tx_byte;
	logic [7:0] tx_repeats;
	logic       tx_line;
	logic [7:0] rpt_setting;

	trfs_pkg::result_t line_results_q [$];
	int      errors;
	int      n_req, n_results, n_taken, n_rejected, n_frames, n_cfg;
	int      idle_cycles;
	int      burst_left;
	bit      no_idle, rx_quiet, hold_req;
	bit      cur_typed;
	trfs_pkg::result_t cur_want;
	stim_row_t dir_rows [N_DIR];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic trfs_pkg::result_t predict_line(logic k, logic [4:0] g,
			logic [2:0] u, logic fon);
		trfs_pkg::result_t r;
		r.command_accepted = 1'b0;
		if (k == trfs_pkg::KIND_CMD) begin
			if (u <= trfs_pkg::MAX_UNIT) begin
				for (int i = 0; i < FB; i++)
					tx_frame[i] = 8'h00;
				for (int i = 0; i < int'(trfs_pkg::UNIT_POS); i++)
					tx_frame[i] = g[i] ? trfs_pkg::CODE_ZERO : trfs_pkg::CODE_FLOAT;
				for (int i = int'(trfs_pkg::UNIT_POS); i < int'(trfs_pkg::FUNC_POS); i++)
					tx_frame[i] = (i - int'(trfs_pkg::UNIT_POS) == int'(u))
						? trfs_pkg::CODE_ZERO : trfs_pkg::CODE_FLOAT;
				tx_frame[trfs_pkg::FUNC_POS] = fon ? trfs_pkg::CODE_ZERO : trfs_pkg::CODE_ONE;
				tx_frame[trfs_pkg::FUNC2_POS] = fon ? trfs_pkg::CODE_ONE : trfs_pkg::CODE_ZERO;
				tx_frame[trfs_pkg::SYNC_POS] = trfs_pkg::CODE_SYNC;
				tx_bit = 3'd0;
				tx_byte = 0;
				tx_repeats = rpt_setting;
				r.command_accepted = 1'b1;
				n_taken++;
			end else begin
				n_rejected++;
			end
		end else if (tx_repeats != 8'd0) begin
			tx_line = tx_frame[tx_byte][3'd7 - tx_bit];
			if (tx_bit == 3'd7) begin
				tx_byte++;
				if (tx_byte == FB) begin
					tx_byte = 0;
					tx_repeats = tx_repeats - 8'd1;
					n_frames++;
				end
			end
			tx_bit = tx_bit + 3'd1;
		end
		r.line_level = tx_line;
		r.sending = (tx_repeats != 8'd0);
		return r;
	endfunction

	task automatic check_bit(string name, logic want, logic got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0b got %0b", $time, name, want, got);
		end
	endtask

	// result checking, request prediction and the watchdog
	always @(posedge clk) begin : monitor
		trfs_pkg::result_t want;
		trfs_pkg::result_t pred;
		if (arst_n) begin
			idle_cycles++;
			if (out_valid && !out_stall) begin
				idle_cycles = 0;
				n_results++;
				if (line_results_q.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected, got %0b%0b%0b", $time,
						line_level, sending, command_accepted);
				end else begin
					want = line_results_q.pop_front();
					check_bit("line_level", want.line_level, line_level);
					check_bit("sending", want.sending, sending);
					check_bit("command_accepted", want.command_accepted, command_accepted);
				end
			end
			if (in_valid && !in_stall) begin
				idle_cycles = 0;
				n_req++;
				pred = predict_line(kind, group_bits, unit_index, function_on);
				line_results_q.push_back(cur_typed ? cur_want : pred);
			end
			if (psel && penable)
				idle_cycles = 0;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no request or result moved for %0d cycles", $time,
					WATCHDOG_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// receiver stall pattern
	initial begin : receiver
		rx_mode_t mode;
		int       cnt;
		int       ph;
		out_stall = 1'b0;
		mode = RX_FREE;
		cnt = 0;
		ph = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (rx_quiet) begin
				out_stall <= 1'b0;
			end else begin
				if (cnt == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					cnt = $urandom_range(20, 100);
				end
				cnt--;
				ph++;
				case (mode)
					RX_FREE: out_stall <= 1'b0;
					RX_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ((ph % 5) < 2);
				endcase
			end
		end
	end

	task automatic send_req(logic k, logic [4:0] g, logic [2:0] u, logic fon,
			bit typed = 1'b0, trfs_pkg::result_t want = '0);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!no_idle) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		group_bits <= g;
		unit_index <= u;
		function_on <= fon;
		cur_typed = typed;
		cur_want = want;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (line_results_q.size() != 0) @(posedge clk);
	endtask

	// optional write of repeat_count, then a read back against the local copy
	task automatic cfg_repeat(bit do_write, logic [7:0] v);
		if (do_write) begin
			@(negedge clk);
			psel <= 1'b1;
			pwrite <= 1'b1;
			penable <= 1'b0;
			paddr <= ADDR_REPEAT;
			pwdata <= 32'(v);
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			rpt_setting = v;
			n_cfg++;
		end
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= ADDR_REPEAT;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(rpt_setting)) begin
			errors++;
			$display("%0t: repeat_count read expected %0h got %0h", $time,
				32'(rpt_setting), prdata);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : stimulus
		logic [7:0] rpt_plan [N_PHASES];
		int budget, n, r, s;
		in_valid = 1'b0;
		kind = trfs_pkg::KIND_TICK;
		group_bits = '0;
		unit_index = '0;
		function_on = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		errors = 0;
		idle_cycles = 0;
		burst_left = 0;
		no_idle = 1'b0;
		rx_quiet = 1'b0;
		hold_req = 1'b0;
		cur_typed = 1'b0;
		cur_want = '0;
		n_req = 0; n_results = 0; n_taken = 0; n_rejected = 0; n_frames = 0; n_cfg = 0;
		tx_bit = 3'd0;
		tx_byte = 0;
		tx_repeats = 8'd0;
		tx_line = 1'b0;
		rpt_setting = trfs_pkg::REPEAT_RESET;
		rpt_plan = '{8'd1, 8'd2, 8'd255, 8'd1, 8'd0, 8'd3, 8'd0, 8'd1};

		// want bits: line_level, sending, command_accepted
		dir_rows = '{
			'{ROW_REQ, trfs_pkg::KIND_TICK, 5'd31, 3'd7, 1'b1, 8'd0, 1'b1, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_CMD,  5'd31, 3'd5, 1'b1, 8'd0, 1'b1, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_CMD,  5'd0,  3'd7, 1'b0, 8'd0, 1'b1, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_CMD,  5'd0,  3'd0, 1'b0, 8'd0, 1'b1, 3'b011},
			'{ROW_REQ, trfs_pkg::KIND_TICK, 5'd0,  3'd0, 1'b0, 8'd0, 1'b1, 3'b110},
			'{ROW_REQ, trfs_pkg::KIND_TICK, 5'd31, 3'd7, 1'b1, 8'd0, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_CMD,  5'd0,  3'd6, 1'b1, 8'd0, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_TICK, 5'd0,  3'd0, 1'b0, 8'd0, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_CMD,  5'd31, 3'd4, 1'b1, 8'd0, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_TICK, 5'd0,  3'd0, 1'b0, 8'd0, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_TICK, 5'd0,  3'd0, 1'b0, 8'd0, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_CMD,  5'd21, 3'd1, 1'b0, 8'd0, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_TICK, 5'd10, 3'd2, 1'b1, 8'd0, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_CMD,  5'd10, 3'd2, 1'b1, 8'd0, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_TICK, 5'd21, 3'd5, 1'b0, 8'd0, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_CMD,  5'd0,  3'd3, 1'b0, 8'd0, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_TICK, 5'd0,  3'd0, 1'b0, 8'd0, 1'b0, 3'b000},
			'{ROW_CFG, trfs_pkg::KIND_TICK, 5'd0,  3'd0, 1'b0, 8'd0, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_CMD,  5'd31, 3'd0, 1'b1, 8'd0, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_TICK, 5'd0,  3'd0, 1'b0, 8'd0, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_TICK, 5'd31, 3'd7, 1'b1, 8'd0, 1'b0, 3'b000},
			'{ROW_CFG, trfs_pkg::KIND_TICK, 5'd0,  3'd0, 1'b0, 8'd255, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_CMD,  5'd0,  3'd4, 1'b0, 8'd0, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_TICK, 5'd0,  3'd0, 1'b0, 8'd0, 1'b0, 3'b000},
			'{ROW_REQ, trfs_pkg::KIND_TICK, 5'd0,  3'd0, 1'b0, 8'd0, 1'b0, 3'b000}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		cfg_repeat(1'b0, 8'd0);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].op == ROW_CFG) begin
				wait_drained();
				cfg_repeat(1'b1, dir_rows[i].rpt);
			end else begin
				send_req(dir_rows[i].k, dir_rows[i].grp, dir_rows[i].unit, dir_rows[i].fon,
					dir_rows[i].typed, dir_rows[i].want);
			end
		end

		for (int p = 0; p < N_PHASES; p++) begin
			s = (p == RND_PHASE) ? $urandom_range(4, 254) : int'(rpt_plan[p]);
			wait_drained();
			no_idle = (p == HOLD_PHASE) || (p == QUIET_PHASE);
			rx_quiet = (p == QUIET_PHASE);
			cfg_repeat(1'b1, 8'(s));
			if (p == HOLD_PHASE)
				hold_req = 1'b1;
			budget = 0;
			while (budget < PHASE_ITEMS) begin
				r = $urandom_range(0, 9);
				n = 0;
				if (r < 7) begin
					// well-formed: a valid command followed by a run of ticks
					send_req(trfs_pkg::KIND_CMD, 5'($urandom),
						3'($urandom_range(0, trfs_pkg::MAX_UNIT)), 1'($urandom));
					n = (s != 0 && s <= 2) ? $urandom_range(100, s * FB * 8 + 20)
						: $urandom_range(1, 140);
				end else if (r == 7) begin
					send_req(trfs_pkg::KIND_CMD, 5'($urandom),
						3'($urandom_range(trfs_pkg::MAX_UNIT + 1, 7)), 1'($urandom));
				end else if (r == 8) begin
					repeat ($urandom_range(1, 5))
						send_req(1'($urandom), 5'($urandom), 3'($urandom), 1'($urandom));
				end else begin
					n = $urandom_range(1, 20);
				end
				repeat (n)
					send_req(trfs_pkg::KIND_TICK, 5'($urandom), 3'($urandom), 1'($urandom));
				budget += n + 1;
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("%0d requests, %0d results: %0d commands taken, %0d rejected, %0d frames sent",
			n_req, n_results, n_taken, n_rejected, n_frames);
		$display("%0d repeat_count writes incl. 0, 1 and 255, with one long output hold-off",
			n_cfg);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
